// ===== rtl/csc_pkg.sv =====
// shared types and constants of the curve segment classifier
package csc_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NVALS         = 6;
  localparam int FLD_BITS      = 3;
  localparam int TYPE_BITS     = 4;
  localparam int NTESTS        = 4;
  localparam int CFG_IDX_BITS  = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_EIG_LOW  = 1'b0,
    CFG_EIG_HIGH = 1'b1
  } cfg_idx_t;

  // where the current curve stands
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_INSIDE = 2'd2
  } phase_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_EVAL     = 3'd1,
    S_DIV_GO   = 3'd2,
    S_DIV_WAIT = 3'd3,
    S_MUL_GO   = 3'd4,
    S_MUL_WAIT = 3'd5,
    S_EMIT_X   = 3'd6,
    S_EMIT_CUR = 3'd7
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_sel;
    logic mul_start;
    logic mul_pass;
    logic load_x;
    logic x_close;
    logic load_cur;
    logic cur_start;
    logic cur_err;
    logic commit;
  } csc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic div_done;
    logic mul_done;
    logic curve_end;
    logic same_type;
    logic cross_one;
    logic cross_two;
  } csc_sts_t;

endpackage

// ===== rtl/csc_in_if.sv =====
// input item channel: one curve point
interface csc_in_if #(
  parameter int WORD_BITS = csc_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] coord_0;
  logic signed [WORD_BITS-1:0] coord_1;
  logic signed [WORD_BITS-1:0] coord_2;
  logic signed [WORD_BITS-1:0] speed;
  logic signed [WORD_BITS-1:0] eig_low;
  logic signed [WORD_BITS-1:0] eig_high;
  logic                        curve_end;

  modport source (output valid, coord_0, coord_1, coord_2, speed, eig_low, eig_high,
                  curve_end, input ready);
  modport sink (input valid, coord_0, coord_1, coord_2, speed, eig_low, eig_high,
                curve_end, output ready);
endinterface

// ===== rtl/csc_out_if.sv =====
// result item channel: one emitted point with its tags
interface csc_out_if #(
  parameter int WORD_BITS = csc_pkg::WORD_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic signed [WORD_BITS-1:0]        out_coord_0;
  logic signed [WORD_BITS-1:0]        out_coord_1;
  logic signed [WORD_BITS-1:0]        out_coord_2;
  logic signed [WORD_BITS-1:0]        out_speed;
  logic signed [WORD_BITS-1:0]        out_eig_low;
  logic signed [WORD_BITS-1:0]        out_eig_high;
  logic [csc_pkg::TYPE_BITS-1:0]      segment_type;
  logic                               segment_start;
  logic                               interpolated;
  logic                               interp_error;
  logic                               run_last;

  modport source (output valid, out_coord_0, out_coord_1, out_coord_2, out_speed,
                  out_eig_low, out_eig_high, segment_type, segment_start, interpolated,
                  interp_error, run_last, input ready);
  modport sink (input valid, out_coord_0, out_coord_1, out_coord_2, out_speed,
                out_eig_low, out_eig_high, segment_type, segment_start, interpolated,
                interp_error, run_last, output ready);
endinterface

// ===== rtl/csc_ctrl.sv =====
// controller state machine: sequences classify, divide, blend and emit
module csc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csc_pkg::csc_sts_t sts,
  output csc_pkg::csc_cmd_t cmd
);

  csc_pkg::state_t state_r, state_nxt;
  csc_pkg::phase_t phase_r, phase_nxt;
  logic            div_idx_r, div_idx_nxt;
  logic            pass_r, pass_nxt;
  logic            cur_start_r, cur_start_nxt;
  logic            cur_err_r, cur_err_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csc_pkg::S_IDLE;
      phase_r     <= csc_pkg::PH_FIRST;
      div_idx_r   <= 1'b0;
      pass_r      <= 1'b0;
      cur_start_r <= 1'b0;
      cur_err_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      div_idx_r   <= div_idx_nxt;
      pass_r      <= pass_nxt;
      cur_start_r <= cur_start_nxt;
      cur_err_r   <= cur_err_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    div_idx_nxt   = div_idx_r;
    pass_nxt      = pass_r;
    cur_start_nxt = cur_start_r;
    cur_err_nxt   = cur_err_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.div_sel   = div_idx_r;
    cmd.mul_pass  = pass_r;
    cmd.x_close   = sts.cross_two && !pass_r;
    cmd.cur_start = cur_start_r;
    cmd.cur_err   = cur_err_r;
    case (state_r)
      csc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = csc_pkg::S_EVAL;
        end
      end
      csc_pkg::S_EVAL: begin
        if (phase_r == csc_pkg::PH_FIRST) begin
          phase_nxt = sts.curve_end ? csc_pkg::PH_FIRST : csc_pkg::PH_SECOND;
          state_nxt = csc_pkg::S_IDLE;
        end else if (phase_r == csc_pkg::PH_SECOND || sts.same_type) begin
          cur_start_nxt = (phase_r == csc_pkg::PH_SECOND);
          cur_err_nxt   = 1'b0;
          state_nxt     = csc_pkg::S_EMIT_CUR;
        end else if (sts.cross_one || sts.cross_two) begin
          div_idx_nxt = 1'b0;
          state_nxt   = csc_pkg::S_DIV_GO;
        end else begin
          cur_start_nxt = 1'b1;
          cur_err_nxt   = 1'b1;
          state_nxt     = csc_pkg::S_EMIT_CUR;
        end
      end
      csc_pkg::S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = csc_pkg::S_DIV_WAIT;
      end
      csc_pkg::S_DIV_WAIT: begin
        if (sts.div_done) begin
          if (!div_idx_r && sts.cross_two) begin
            div_idx_nxt = 1'b1;
            state_nxt   = csc_pkg::S_DIV_GO;
          end else begin
            pass_nxt  = 1'b0;
            state_nxt = csc_pkg::S_MUL_GO;
          end
        end
      end
      csc_pkg::S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_nxt     = csc_pkg::S_MUL_WAIT;
      end
      csc_pkg::S_MUL_WAIT: begin
        if (sts.mul_done) state_nxt = csc_pkg::S_EMIT_X;
      end
      csc_pkg::S_EMIT_X: begin
        if (sts.out_free) begin
          cmd.load_x = 1'b1;
          if (sts.cross_two && !pass_r) begin
            pass_nxt  = 1'b1;
            state_nxt = csc_pkg::S_MUL_GO;
          end else begin
            cur_start_nxt = 1'b0;
            cur_err_nxt   = 1'b0;
            state_nxt     = csc_pkg::S_EMIT_CUR;
          end
        end
      end
      csc_pkg::S_EMIT_CUR: begin
        if (sts.out_free) begin
          cmd.load_cur = 1'b1;
          cmd.commit   = 1'b1;
          phase_nxt    = sts.curve_end ? csc_pkg::PH_FIRST : csc_pkg::PH_INSIDE;
          state_nxt    = csc_pkg::S_IDLE;
        end
      end
      default: state_nxt = csc_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/csc_datapath.sv =====
// datapath: point registers, tests, serial divider, serial blender, output register
module csc_datapath #(
  parameter int WORD_BITS = csc_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = csc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [csc_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [WORD_BITS-1:0]              cfg_data,
  input  logic signed [WORD_BITS-1:0]       in_val [csc_pkg::NVALS],
  input  logic                              in_end,
  input  csc_pkg::csc_cmd_t                 cmd,
  output csc_pkg::csc_sts_t                 sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [WORD_BITS-1:0]       out_val [csc_pkg::NVALS],
  output logic [csc_pkg::TYPE_BITS-1:0]     out_type,
  output logic                              out_start,
  output logic                              out_interp,
  output logic                              out_err,
  output logic                              out_last
);

  localparam int DW   = WORD_BITS + 1;         // test difference
  localparam int DENW = WORD_BITS + 2;         // divisor
  localparam int RW   = WORD_BITS + 3;         // remainder
  localparam int AW   = FRAC_BITS + 1;         // alpha
  localparam int PW   = DW + AW;               // product
  localparam int CW   = $clog2(AW);
  localparam int NV   = csc_pkg::NVALS;
  localparam int FB   = csc_pkg::FLD_BITS;
  localparam int TB   = csc_pkg::TYPE_BITS;
  localparam int NT   = csc_pkg::NTESTS;
  localparam logic [CW-1:0] BIT_LAST = CW'(AW - 1);
  localparam logic [FB-1:0] FLD_LAST = FB'(NV - 1);
  localparam logic [PW:0]   HALF     = (PW+1)'(1) << (FRAC_BITS - 1);

  logic signed [WORD_BITS-1:0] ref_lo_r, ref_hi_r;
  logic signed [WORD_BITS-1:0] cur_r [NV];
  logic signed [WORD_BITS-1:0] prev_r [NV];
  logic signed [WORD_BITS-1:0] blend_r [NV];
  logic                        end_r;
  logic [TB-1:0]               prev_type_r;
  logic [TB-1:0]               cur_type;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lo_r <= '0;
      ref_hi_r <= '0;
    end else if (cfg_we) begin
      case (csc_pkg::cfg_idx_t'(cfg_idx))
        csc_pkg::CFG_EIG_LOW:  ref_lo_r <= cfg_data;
        csc_pkg::CFG_EIG_HIGH: ref_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // current and previous point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_type_r <= '0;
      for (int i = 0; i < NV; i++) prev_r[i] <= '0;
    end else if (cmd.commit) begin
      prev_type_r <= cur_type;
      for (int i = 0; i < NV; i++) prev_r[i] <= cur_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      end_r <= in_end;
      for (int i = 0; i < NV; i++) cur_r[i] <= in_val[i];
    end
  end

  // test differences value - speed of both points
  logic signed [DW-1:0] dq [NT];
  logic signed [DW-1:0] dp [NT];
  logic [NT-1:0]        chg;

  always_comb begin
    dq[0] = DW'(ref_lo_r) - DW'(cur_r[3]);
    dq[1] = DW'(ref_hi_r) - DW'(cur_r[3]);
    dq[2] = DW'(cur_r[4]) - DW'(cur_r[3]);
    dq[3] = DW'(cur_r[5]) - DW'(cur_r[3]);
    dp[0] = DW'(ref_lo_r) - DW'(prev_r[3]);
    dp[1] = DW'(ref_hi_r) - DW'(prev_r[3]);
    dp[2] = DW'(prev_r[4]) - DW'(prev_r[3]);
    dp[3] = DW'(prev_r[5]) - DW'(prev_r[3]);
    for (int k = 0; k < NT; k++) begin
      cur_type[k] = ~dq[k][DW-1];
      chg[k] = (dp[k][DW-1] != dq[k][DW-1]) || ((dp[k] == '0) != (dq[k] == '0));
    end
  end

  // pick the tests that changed sign
  logic [1:0] idx_lo, idx_hi, idx_sel;
  logic [2:0] cnt;

  always_comb begin
    idx_lo = '0;
    idx_hi = '0;
    for (int k = NT - 1; k >= 0; k--) if (chg[k]) idx_lo = 2'(k);
    for (int k = 0; k < NT; k++) if (chg[k]) idx_hi = 2'(k);
    cnt = 3'($countones(chg));
  end

  // divider operands for the selected crossing
  logic signed [DW-1:0]   fq, fp;
  logic signed [DENW-1:0] fdiff;
  logic [DW-1:0]          num;
  logic [DENW-1:0]        den;

  always_comb begin
    idx_sel = cmd.div_sel ? idx_hi : idx_lo;
    fq      = dq[idx_sel];
    fp      = dp[idx_sel];
    fdiff   = DENW'(fq) - DENW'(fp);
    num     = fq[DW-1] ? DW'(-fq) : DW'(fq);
    den     = fdiff[DENW-1] ? DENW'(-fdiff) : DENW'(fdiff);
  end

  // restoring divider, one quotient bit per cycle
  logic [RW-1:0]   rem_r, rem_sh;
  logic [DENW-1:0] den_r;
  logic [AW-1:0]   q_r, q_nxt;
  logic [CW-1:0]   dcnt_r;
  logic            div_busy_r, div_tgt_r, div_ge;
  logic [AW-1:0]   alpha_r [2];

  always_comb begin
    rem_sh = (dcnt_r == '0) ? rem_r : {rem_r[RW-2:0], 1'b0};
    div_ge = rem_sh >= RW'(den_r);
    q_nxt  = {q_r[AW-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && dcnt_r == BIT_LAST) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r     <= RW'(num);
      den_r     <= den;
      q_r       <= '0;
      dcnt_r    <= '0;
      div_tgt_r <= cmd.div_sel;
    end else if (div_busy_r) begin
      rem_r  <= div_ge ? rem_sh - RW'(den_r) : rem_sh;
      q_r    <= q_nxt;
      dcnt_r <= dcnt_r + 1'b1;
      if (dcnt_r == BIT_LAST) alpha_r[div_tgt_r] <= q_nxt;
    end
  end

  // larger alpha closes the old segment first
  logic [AW-1:0] a_hi, a_lo;
  always_comb begin
    if (cnt == 3'd2 && alpha_r[1] > alpha_r[0]) begin
      a_hi = alpha_r[1];
      a_lo = alpha_r[0];
    end else begin
      a_hi = alpha_r[0];
      a_lo = alpha_r[1];
    end
  end

  // shift-add blender, one alpha bit per cycle, one field after another
  logic [AW-1:0]        m_alpha_r, m_sh_r;
  logic [PW-1:0]        acc_r, acc_nxt;
  logic [CW-1:0]        mbit_r;
  logic [FB-1:0]        fld_r;
  logic                 mul_busy_r;
  logic signed [DW-1:0] bd;
  logic [DW-1:0]        bmag;
  logic [PW:0]          rnd;
  logic [WORD_BITS-1:0] rq;

  always_comb begin
    bd      = DW'(prev_r[fld_r]) - DW'(cur_r[fld_r]);
    bmag    = bd[DW-1] ? DW'(-bd) : DW'(bd);
    acc_nxt = {acc_r[PW-2:0], 1'b0} + (m_sh_r[AW-1] ? PW'(bmag) : '0);
    rnd     = (PW+1)'(acc_nxt) + HALF;
    rq      = WORD_BITS'(rnd >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
    end else if (cmd.mul_start) begin
      mul_busy_r <= 1'b1;
    end else if (mul_busy_r && mbit_r == BIT_LAST && fld_r == FLD_LAST) begin
      mul_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      m_alpha_r <= cmd.mul_pass ? a_lo : a_hi;
      m_sh_r    <= cmd.mul_pass ? a_lo : a_hi;
      acc_r     <= '0;
      mbit_r    <= '0;
      fld_r     <= '0;
    end else if (mul_busy_r) begin
      if (mbit_r == BIT_LAST) begin
        blend_r[fld_r] <= bd[DW-1] ? cur_r[fld_r] - rq : cur_r[fld_r] + rq;
        acc_r  <= '0;
        mbit_r <= '0;
        m_sh_r <= m_alpha_r;
        fld_r  <= fld_r + 1'b1;
      end else begin
        acc_r  <= acc_nxt;
        mbit_r <= mbit_r + 1'b1;
        m_sh_r <= {m_sh_r[AW-2:0], 1'b0};
      end
    end
  end

  // output register
  logic out_valid_r;
  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_x || cmd.load_cur) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      for (int i = 0; i < NV; i++) out_val[i] <= blend_r[i];
      out_type   <= cmd.x_close ? prev_type_r : cur_type;
      out_start  <= !cmd.x_close;
      out_interp <= 1'b1;
      out_err    <= 1'b0;
      out_last   <= 1'b0;
    end else if (cmd.load_cur) begin
      for (int i = 0; i < NV; i++) out_val[i] <= cur_r[i];
      out_type   <= cur_type;
      out_start  <= cmd.cur_start;
      out_interp <= 1'b0;
      out_err    <= cmd.cur_err;
      out_last   <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  // status to controller
  always_comb begin
    sts.out_free  = out_free;
    sts.div_done  = div_busy_r && dcnt_r == BIT_LAST;
    sts.mul_done  = mul_busy_r && mbit_r == BIT_LAST && fld_r == FLD_LAST;
    sts.curve_end = end_r;
    sts.same_type = cur_type == prev_type_r;
    sts.cross_one = cnt == 3'd1;
    sts.cross_two = cnt == 3'd2;
  end

endmodule

// ===== rtl/curve_segment_classifier_unit.sv =====
// top level of the curve segment classifier
// Takes curve points one item at a time and emits one to three result items per
// point (none for the first point of a curve). A point of unchanged type passes
// through evaluation after acceptance and then loads its result into the output
// register. On a type change each crossing costs one pass of the bit-serial
// divider and one pass of the shift-add blender over the six values, plus the
// load of the crossing; the default widths give Q16.16, and each result load
// waits while the output register is held. The next item is taken once the
// current one has loaded its last result into the output register, and config
// may be written only while no item is in flight. No clearing pass after reset.
module curve_segment_classifier_unit #(
  parameter int WORD_BITS = csc_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = csc_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [csc_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [WORD_BITS-1:0]             cfg_data,
  csc_in_if.sink                           in_pt,
  csc_out_if.source                        out_pt
);

  csc_pkg::csc_cmd_t           cmd;
  csc_pkg::csc_sts_t           sts;
  logic signed [WORD_BITS-1:0] in_val  [csc_pkg::NVALS];
  logic signed [WORD_BITS-1:0] out_val [csc_pkg::NVALS];
  logic                        in_ready;

  // payload gathering
  assign in_val[0] = in_pt.coord_0;
  assign in_val[1] = in_pt.coord_1;
  assign in_val[2] = in_pt.coord_2;
  assign in_val[3] = in_pt.speed;
  assign in_val[4] = in_pt.eig_low;
  assign in_val[5] = in_pt.eig_high;
  assign in_pt.ready = in_ready;

  assign out_pt.out_coord_0  = out_val[0];
  assign out_pt.out_coord_1  = out_val[1];
  assign out_pt.out_coord_2  = out_val[2];
  assign out_pt.out_speed    = out_val[3];
  assign out_pt.out_eig_low  = out_val[4];
  assign out_pt.out_eig_high = out_val[5];

  csc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pt.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csc_datapath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_val     (in_val),
    .in_end     (in_pt.curve_end),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_pt.ready),
    .out_valid  (out_pt.valid),
    .out_val    (out_val),
    .out_type   (out_pt.segment_type),
    .out_start  (out_pt.segment_start),
    .out_interp (out_pt.interpolated),
    .out_err    (out_pt.interp_error),
    .out_last   (out_pt.run_last)
  );

endmodule

// ===== rtl/csc_checker.sv =====
// port-level checker of the classifier and its bind
module csc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic seg_start,
  input logic interp,
  input logic err,
  input logic last
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an error result is the lone result and opens a segment
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err |-> last && seg_start && !interp)
    else $error("bad error result");

  // a crossing is never the last result of its item
  a_interp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && interp |-> !last && !err)
    else $error("crossing marked last");

  // after a closing crossing comes the opening crossing
  a_close_then_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && interp && !seg_start |=>
      !out_valid || (interp && seg_start))
    else $error("closing crossing not followed by opening one");

endmodule

bind curve_segment_classifier_unit csc_checker u_csc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_pt.valid),
  .out_ready (out_pt.ready),
  .seg_start (out_pt.segment_start),
  .interp    (out_pt.interpolated),
  .err       (out_pt.interp_error),
  .last      (out_pt.run_last)
);
